// ===== design/pfba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Shared codes, control word and flag structs for the microcoded sequencer
// and its datapath.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Fixed field widths.
  localparam int unsigned OpW     = 3;
  localparam int unsigned PageW   = 20;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FrameW  = 13;
  localparam int unsigned KendW   = 14;
  localparam int unsigned DataW   = 32;

  // Request operation codes.
  typedef enum logic [OpW-1:0] {
    OP_INIT     = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_ALLOC_AT = 3'd2,
    OP_FREE     = 3'd3,
    OP_QUERY    = 3'd4
  } op_e;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FREE  = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_KERNEL    = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_RANGE     = 3'd5
  } status_e;

  // Microprogram steps.
  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_INIT_END,
    S_AL_RD,
    S_AL_TST,
    S_AL_NXT,
    S_AL_SET,
    S_AA_RD,
    S_AA_CHK,
    S_AA_SET,
    S_FR_RD,
    S_FR_CHK,
    S_FR_TST,
    S_FR_CLR,
    S_QY_RD,
    S_QY_CHK,
    S_EM_OK,
    S_EM_NOTFREE,
    S_EM_NOFREE,
    S_EM_KERNEL,
    S_EM_DOUBLE,
    S_EM_RANGE
  } step_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_LAST,
    C_NOT_FULL,
    C_PAGE_FREE,
    C_KERNEL,
    C_CLEAR
  } cond_e;

  // Word pointer operations.
  typedef enum logic [1:0] {
    P_HOLD,
    P_ZERO,
    P_INC
  } ptr_op_e;

  // Bitmap address select.
  typedef enum logic [1:0] {
    A_PTR,
    A_NEXT,
    A_PAGE
  } addr_sel_e;

  // Bitmap write data select.
  typedef enum logic [1:0] {
    W_INIT,
    W_SETK,
    W_SETP,
    W_CLRP
  } wd_sel_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic      accept;
    logic      wipe;
    ptr_op_e   ptr_op;
    addr_sel_e addr_sel;
    logic      re;
    logic      we;
    wd_sel_e   wd_sel;
    logic      ld_pf;
    logic      ld_frame_k;
    logic      ld_frame_p;
    logic      clr_done;
    logic      emit;
    status_e   status;
    cond_e     cond;
    step_e     tgt_t;
    step_e     tgt_f;
  } ctrl_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic           take;
    logic [OpW-1:0] op;
    logic           in_range;
    logic           last;
    logic           not_full;
    logic           page_free;
    logic           kernel;
    logic           busy;
  } flags_t;

endpackage

// ===== design/pfba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one operation and its page number.
// ----------------------------------------------------------------------------
interface pfba_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [19:0] page;

  modport source (output valid, output op, output page, input ready);
  modport sink (input valid, input op, input page, output ready);
endinterface

// ===== design/pfba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying status, frame and the prior free bit.
// ----------------------------------------------------------------------------
interface pfba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [12:0] frame;
  logic        page_free;

  modport source (output valid, output status, output frame, output page_free, input ready);
  modport sink (input valid, input status, input frame, input page_free, output ready);
endinterface

// ===== design/pfba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pfba_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator microsequencer
// Step counter, microprogram ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module pfba_seq import pfba_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  step_e upc_q, upc_d;
  logic  clr_q, clr_d;
  ctrl_t rom;
  logic  stall;
  logic  cond_hit;
  step_e disp_tgt;

  // Microprogram ROM: one control word per step.
  always_comb begin
    rom = '0;
    case (upc_q)
      S_IDLE: begin
        rom.accept = 1'b1;
        rom.ptr_op = P_ZERO;
        rom.cond   = C_DISPATCH;
      end
      S_INIT: begin
        rom.we       = 1'b1;
        rom.wd_sel   = W_INIT;
        rom.addr_sel = A_PTR;
        rom.ptr_op   = P_INC;
        rom.cond     = C_LAST;
        rom.tgt_t    = S_INIT_END;
        rom.tgt_f    = S_INIT;
      end
      S_INIT_END: begin
        rom.clr_done = 1'b1;
        rom.cond     = C_CLEAR;
        rom.tgt_t    = S_IDLE;
        rom.tgt_f    = S_EM_OK;
      end
      S_AL_RD: begin
        rom.re       = 1'b1;
        rom.addr_sel = A_PTR;
        rom.tgt_f    = S_AL_TST;
        rom.tgt_t    = S_AL_TST;
      end
      S_AL_TST: begin
        rom.cond  = C_NOT_FULL;
        rom.tgt_t = S_AL_SET;
        rom.tgt_f = S_AL_NXT;
      end
      S_AL_NXT: begin
        rom.re       = 1'b1;
        rom.addr_sel = A_NEXT;
        rom.ptr_op   = P_INC;
        rom.cond     = C_LAST;
        rom.tgt_t    = S_EM_NOFREE;
        rom.tgt_f    = S_AL_TST;
      end
      S_AL_SET: begin
        rom.we         = 1'b1;
        rom.addr_sel   = A_PTR;
        rom.wd_sel     = W_SETK;
        rom.ld_frame_k = 1'b1;
        rom.tgt_t      = S_EM_OK;
        rom.tgt_f      = S_EM_OK;
      end
      S_AA_RD: begin
        rom.re       = 1'b1;
        rom.addr_sel = A_PAGE;
        rom.tgt_t    = S_AA_CHK;
        rom.tgt_f    = S_AA_CHK;
      end
      S_AA_CHK: begin
        rom.ld_pf = 1'b1;
        rom.cond  = C_PAGE_FREE;
        rom.tgt_t = S_AA_SET;
        rom.tgt_f = S_EM_NOTFREE;
      end
      S_AA_SET: begin
        rom.we         = 1'b1;
        rom.addr_sel   = A_PAGE;
        rom.wd_sel     = W_SETP;
        rom.ld_frame_p = 1'b1;
        rom.tgt_t      = S_EM_OK;
        rom.tgt_f      = S_EM_OK;
      end
      S_FR_RD: begin
        rom.re       = 1'b1;
        rom.addr_sel = A_PAGE;
        rom.tgt_t    = S_FR_CHK;
        rom.tgt_f    = S_FR_CHK;
      end
      S_FR_CHK: begin
        rom.ld_pf = 1'b1;
        rom.cond  = C_KERNEL;
        rom.tgt_t = S_EM_KERNEL;
        rom.tgt_f = S_FR_TST;
      end
      S_FR_TST: begin
        rom.cond  = C_PAGE_FREE;
        rom.tgt_t = S_EM_DOUBLE;
        rom.tgt_f = S_FR_CLR;
      end
      S_FR_CLR: begin
        rom.we       = 1'b1;
        rom.addr_sel = A_PAGE;
        rom.wd_sel   = W_CLRP;
        rom.tgt_t    = S_EM_OK;
        rom.tgt_f    = S_EM_OK;
      end
      S_QY_RD: begin
        rom.re       = 1'b1;
        rom.addr_sel = A_PAGE;
        rom.tgt_t    = S_QY_CHK;
        rom.tgt_f    = S_QY_CHK;
      end
      S_QY_CHK: begin
        rom.ld_pf = 1'b1;
        rom.tgt_t = S_EM_OK;
        rom.tgt_f = S_EM_OK;
      end
      S_EM_OK: begin
        rom.emit   = 1'b1;
        rom.status = ST_OK;
      end
      S_EM_NOTFREE: begin
        rom.emit   = 1'b1;
        rom.status = ST_NOT_FREE;
      end
      S_EM_NOFREE: begin
        rom.emit   = 1'b1;
        rom.status = ST_NO_FREE;
      end
      S_EM_KERNEL: begin
        rom.emit   = 1'b1;
        rom.status = ST_KERNEL;
      end
      S_EM_DOUBLE: begin
        rom.emit   = 1'b1;
        rom.status = ST_DOUBLE;
      end
      S_EM_RANGE: begin
        rom.emit   = 1'b1;
        rom.status = ST_RANGE;
      end
      default: begin
        rom = '0;
      end
    endcase
  end

  // Entry point for a newly accepted transaction.
  always_comb begin
    case (flags_i.op)
      OP_INIT:     disp_tgt = S_INIT;
      OP_ALLOC:    disp_tgt = S_AL_RD;
      OP_ALLOC_AT: disp_tgt = flags_i.in_range ? S_AA_RD : S_EM_RANGE;
      OP_FREE:     disp_tgt = flags_i.in_range ? S_FR_RD : S_EM_RANGE;
      OP_QUERY:    disp_tgt = flags_i.in_range ? S_QY_RD : S_EM_RANGE;
      default:     disp_tgt = S_EM_OK;
    endcase
  end

  // Condition select.
  always_comb begin
    case (rom.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_LAST:      cond_hit = flags_i.last;
      C_NOT_FULL:  cond_hit = flags_i.not_full;
      C_PAGE_FREE: cond_hit = flags_i.page_free;
      C_KERNEL:    cond_hit = flags_i.kernel;
      C_CLEAR:     cond_hit = clr_q;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Next step, clearing flag and gated control word.
  always_comb begin
    stall = rom.emit & flags_i.busy;
    clr_d = clr_q;
    if (rom.clr_done) begin
      clr_d = 1'b0;
    end

    if (stall) begin
      upc_d = upc_q;
    end else if (rom.cond == C_DISPATCH) begin
      if (clr_q) begin
        upc_d = S_INIT;
      end else if (flags_i.take) begin
        upc_d = disp_tgt;
      end else begin
        upc_d = S_IDLE;
      end
    end else begin
      upc_d = cond_hit ? rom.tgt_t : rom.tgt_f;
    end

    ctrl_o        = rom;
    ctrl_o.accept = rom.accept & ~clr_q;
    ctrl_o.wipe   = clr_q;
    ctrl_o.emit   = rom.emit & ~flags_i.busy;
  end

  // Step counter; the bitmap is swept clean once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
      clr_q <= 1'b1;
    end else begin
      upc_q <= upc_d;
      clr_q <= clr_d;
    end
  end

endmodule

// ===== design/pfba_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Bitmap RAM, word pointer, page and result registers, and the output stage.
// ----------------------------------------------------------------------------
module pfba_dpath import pfba_pkg::*; #(
  parameter int unsigned WORDS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KendW-1:0] kernel_end_i,
  input  ctrl_t            ctrl_i,
  output flags_t           flags_o,
  pfba_req_if.sink         req_i,
  pfba_rsp_if.source       rsp_o
);

  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PAGES = WORDS * 32;
  localparam int unsigned CW    = PageW + 1;

  localparam logic [DataW-1:0] TopBit   = 32'h8000_0000;
  localparam logic [DataW-1:0] FullWord = 32'hFFFF_FFFF;

  logic [AW-1:0]      ptr_q, ptr_d;
  logic [PageW-1:0]   page_q;
  logic               pf_q;
  logic [FrameW-1:0]  frame_q;
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [FrameW-1:0]  out_frame_q;
  logic               out_pf_q;

  logic               take;
  logic [DataW-1:0]   rdata;
  logic [DataW-1:0]   wdata;
  logic [AW-1:0]      addr;
  logic [DataW-1:0]   mask_p;
  logic [DataW-1:0]   mask_k;
  logic [4:0]         k;
  logic               k_found;
  logic [AW+4:0]      frame_k;
  logic [CW-1:0]      base_w;
  logic [CW-1:0]      lim_w;
  logic [CW-1:0]      diff_w;
  logic [DataW-1:0]   init_word;

  assign take        = req_i.valid & ctrl_i.accept;
  assign req_i.ready = ctrl_i.accept;

  // Lowest free bit of the word just read: first zero from the top.
  always_comb begin
    k       = '0;
    k_found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!k_found && !rdata[31-i]) begin
        k       = 5'(i);
        k_found = 1'b1;
      end
    end
  end

  assign mask_p  = TopBit >> page_q[4:0];
  assign mask_k  = TopBit >> k;
  assign frame_k = {ptr_q, k};

  // Init word: the top (limit - base) bits of a word are reserved.
  always_comb begin
    base_w = CW'({ptr_q, 5'b0});
    lim_w  = ctrl_i.wipe ? '0 : CW'(kernel_end_i);
    diff_w = lim_w - base_w;
    if (lim_w >= base_w + CW'(32)) begin
      init_word = FullWord;
    end else if (lim_w <= base_w) begin
      init_word = '0;
    end else begin
      init_word = ~(FullWord >> diff_w[4:0]);
    end
  end

  // Bitmap address and write data.
  always_comb begin
    case (ctrl_i.addr_sel)
      A_PTR:   addr = ptr_q;
      A_NEXT:  addr = ptr_q + AW'(1);
      A_PAGE:  addr = page_q[5 +: AW];
      default: addr = ptr_q;
    endcase
    case (ctrl_i.wd_sel)
      W_INIT:  wdata = init_word;
      W_SETK:  wdata = rdata | mask_k;
      W_SETP:  wdata = rdata | mask_p;
      W_CLRP:  wdata = rdata & ~mask_p;
      default: wdata = init_word;
    endcase
  end

  pfba_ram #(
    .WIDTH (DataW),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // Word pointer.
  always_comb begin
    case (ctrl_i.ptr_op)
      P_ZERO:  ptr_d = '0;
      P_INC:   ptr_d = ptr_q + AW'(1);
      default: ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Transaction page, prior free bit and allocated frame.
  always_ff @(posedge clk_i) begin
    if (take) begin
      page_q  <= req_i.page;
      pf_q    <= 1'b0;
      frame_q <= '0;
    end else begin
      if (ctrl_i.ld_pf) begin
        pf_q <= ((rdata & mask_p) == '0);
      end
      if (ctrl_i.ld_frame_k) begin
        frame_q <= FrameW'(frame_k);
        pf_q    <= 1'b1;
      end
      if (ctrl_i.ld_frame_p) begin
        frame_q <= page_q[FrameW-1:0];
      end
    end
  end

  // Output register: the result waits here while the sequencer moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_status_q <= ctrl_i.status;
      out_frame_q  <= frame_q;
      out_pf_q     <= pf_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.frame     = out_frame_q;
  assign rsp_o.page_free = out_pf_q;

  // Flags for the sequencer.
  always_comb begin
    flags_o.take      = take;
    flags_o.op        = req_i.op;
    flags_o.in_range  = {1'b0, req_i.page} < CW'(PAGES);
    flags_o.last      = (ptr_q == AW'(WORDS - 1));
    flags_o.not_full  = (rdata != FullWord);
    flags_o.page_free = ((rdata & mask_p) == '0);
    flags_o.kernel    = (page_q < PageW'(kernel_end_i));
    flags_o.busy      = out_valid_q & ~rsp_o.ready;
  end

endmodule

// ===== design/page_frame_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// One used bit per 4 KiB page frame in WORDS words of 32 bits, most
// significant bit holding the lowest page, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_i (op, page) and each produces exactly one response
// on rsp_o (status, frame, page_free); both are valid/ready channels and a
// transaction completes when valid and ready are high at a clock edge.
// One request is worked at a time; the sequencer is back in its idle step,
// ready to accept the next, as the response is registered. Query reads the
// word and checks the bit; alloc-at reads, checks and, unless refused, sets
// it; free reads, checks for a kernel page, tests for a double free and
// clears; out-of-range and unknown ops go straight to the response.
// Alloc reads one bitmap word and tests it in turn through the single RAM
// read port, skipping full words, until it finds a free bit or passes the
// last word. Init rewrites every word, one per cycle. After reset the
// sequencer sweeps the bitmap clear and takes no request until that is
// done. kernel_end_page is cleared to 0 by reset and is to be written by
// the user only while no request is in flight; the block does not check.
// A finished response waits in an output register; the next request is
// accepted meanwhile, and the sequencer holds at its last step only while
// the previous response is still not taken.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_top import pfba_pkg::*; #(
  parameter int unsigned WORDS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             kernel_end_page_we_i,
  input  logic [KendW-1:0] kernel_end_page_i,
  pfba_req_if.sink         req_i,
  pfba_rsp_if.source       rsp_o
);

  logic [KendW-1:0] kernel_end_q;
  ctrl_t            ctrl;
  flags_t           flags;

  // Kernel end register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= '0;
    end else if (kernel_end_page_we_i) begin
      kernel_end_q <= kernel_end_page_i;
    end
  end

  pfba_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  pfba_dpath #(
    .WORDS (WORDS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kernel_end_i (kernel_end_q),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .req_i        (req_i),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame bitmap allocator testbench
// Drives init, alloc, alloc-at, free, query and reserved operations into the
// allocator and checks every response against a cycle-free model of the
// bitmap. Both channels idle at random. One phase holds the response side off
// for a long stretch, and between phases the sender waits for every response
// before kernel_end_page is rewritten.
// ----------------------------------------------------------------------------
module testbench;
  import pfba_pkg::*;

  localparam int unsigned WORDS     = 256;
  localparam int unsigned PAGES     = WORDS * 32;
  localparam int unsigned HOLD_LONG = 400;
  localparam int unsigned MAX_SHOWN = 50;

  // Operation codes outside the package enum; the block answers them with ST_OK and leaves the bitmap as it is.
  localparam logic [OpW-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OpW-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD_HI = 3'd7;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [PageW-1:0] page;
  } alloc_req_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  frame;
    logic               page_free;
  } alloc_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic             kend_we;
  logic [KendW-1:0] kend_data;

  pfba_req_if req ();
  pfba_rsp_if rsp ();

  page_frame_bitmap_allocator_top #(
    .WORDS(WORDS)
  ) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .kernel_end_page_we_i(kend_we),
    .kernel_end_page_i   (kend_data),
    .req_i               (req),
    .rsp_o               (rsp)
  );

  // Model state: the used bitmap and its copy of the kernel end register.
  logic [31:0]      model_used [WORDS];
  logic [KendW-1:0] model_kend;

  alloc_req_t pending_req [$];
  alloc_rsp_t expected_rsp [$];
  alloc_rsp_t want;

  int unsigned error_count;
  int unsigned idle_max;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          long_hold;
  bit          req_taken;
  bit          rsp_taken;

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Computes the response to one operation and updates the model bitmap.
  function automatic alloc_rsp_t predict_allocator(logic [OpW-1:0] op,
                                                   logic [PageW-1:0] page);
    alloc_rsp_t  r;
    int unsigned lim;
    int unsigned w;
    int unsigned b;
    bit          hit;
    logic [31:0] mask;
    logic [7:0]  wi;
    r.status    = ST_OK;
    r.frame     = '0;
    r.page_free = 1'b0;
    mask = 32'h8000_0000 >> page[4:0];
    wi   = page[12:5];
    case (op)
      OP_INIT: begin
        // Reserve only the pages that exist, even if the kernel end is past them.
        lim = (model_kend < PAGES) ? model_kend : PAGES;
        for (w = 0; w < WORDS; w++) begin
          for (b = 0; b < 32; b++) begin
            model_used[w][31-b] = (w * 32 + b < lim);
          end
        end
      end
      OP_ALLOC: begin
        // Lowest free page: all 32 bits of each word are candidates.
        hit      = 1'b0;
        r.status = ST_NO_FREE;
        for (w = 0; w < WORDS; w++) begin
          if (!hit && model_used[w] != 32'hFFFF_FFFF) begin
            for (b = 0; b < 32; b++) begin
              if (!hit && !model_used[w][31-b]) begin
                model_used[w][31-b] = 1'b1;
                r.frame     = FrameW'(w * 32 + b);
                r.page_free = 1'b1;
                r.status    = ST_OK;
                hit         = 1'b1;
              end
            end
          end
        end
      end
      OP_ALLOC_AT, OP_FREE, OP_QUERY: begin
        if (page >= PAGES) begin
          r.status = ST_RANGE;
        end else begin
          r.page_free = ~|(model_used[wi] & mask);
          if (op == OP_ALLOC_AT) begin
            if (r.page_free) begin
              model_used[wi] = model_used[wi] | mask;
              r.frame        = page[FrameW-1:0];
            end else begin
              r.status = ST_NOT_FREE;
            end
          end else if (op == OP_FREE) begin
            // The kernel check wins over the double free check.
            if (page < model_kend) begin
              r.status = ST_KERNEL;
            end else if (r.page_free) begin
              r.status = ST_DOUBLE;
            end else begin
              model_used[wi] = model_used[wi] & ~mask;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Prints one mismatch line (the first MAX_SHOWN only) and counts every one.
  task automatic report_mismatch(string msg);
    if (error_count < MAX_SHOWN) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Sample both channels at the rising edge: predict on each request
  // transaction, check each response transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        expected_rsp.push_back(predict_allocator(req.op, req.page));
        void'(pending_req.pop_front());
        req_taken = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          end
          if (rsp.frame !== want.frame) begin
            report_mismatch($sformatf("frame got %0d want %0d", rsp.frame, want.frame));
          end
          if (rsp.page_free !== want.page_free) begin
            report_mismatch($sformatf("page_free got %0b want %0b",
                                      rsp.page_free, want.page_free));
          end
        end
        rsp_taken = 1'b1;
      end
    end
  end

  // Request driver: holds an offered item until taken, then idles a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(req.valid && !req_taken)) begin
        if (req_taken) begin
          gap_left  = $urandom_range(0, idle_max);
          req_taken = 1'b0;
        end
        if (gap_left == 0 && pending_req.size() > 0) begin
          req.valid <= 1'b1;
          req.op    <= pending_req[0].op;
          req.page  <= pending_req[0].page;
        end else begin
          req.valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
          end
        end
      end
    end
  end

  // Response side: a random stall per transaction, plus one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold) begin
        hold_left = HOLD_LONG;
        long_hold = 1'b0;
      end
      if (rsp_taken) begin
        stall_left = $urandom_range(0, idle_max);
        rsp_taken  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic [OpW-1:0] op, logic [PageW-1:0] page);
    alloc_req_t item;
    item.op   = op;
    item.page = page;
    pending_req.push_back(item);
  endtask

  task automatic wait_idle();
    while (pending_req.size() != 0 || expected_rsp.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Waits until nothing is in flight, writes the kernel end and lines up on a
  // rising edge so that new items are queued away from the driver's edge.
  task automatic start_phase(logic [KendW-1:0] kend);
    wait_idle();
    @(negedge clk_i);
    kend_we   <= 1'b1;
    kend_data <= kend;
    model_kend = kend;
    @(negedge clk_i);
    kend_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random phase: mostly operations on pages near the kernel end, where
  // allocations land, so that frees and alloc-at hit used and free pages alike.
  task automatic random_phase(int unsigned kend, bit do_init, int unsigned count, bit hold);
    int unsigned     roll;
    int unsigned     lo;
    int unsigned     i;
    logic [OpW-1:0]  op;
    logic [PageW-1:0] page;
    start_phase(kend[KendW-1:0]);
    long_hold = hold;
    if (do_init) begin
      queue_req(OP_INIT, PageW'($urandom));
    end
    lo = (kend > 40) ? kend - 40 : 0;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        op = OP_INIT;
      end else if (roll < 32) begin
        op = OP_ALLOC;
      end else if (roll < 54) begin
        op = OP_ALLOC_AT;
      end else if (roll < 79) begin
        op = OP_FREE;
      end else if (roll < 95) begin
        op = OP_QUERY;
      end else begin
        op = OpW'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        page = PageW'(lo + $urandom_range(0, 240));
      end else if (roll < 85) begin
        page = PageW'($urandom_range(0, PAGES - 1));
      end else if (roll < 95) begin
        page = PageW'($urandom);
      end else begin
        page = PageW'(PAGES - 2 + $urandom_range(0, 3));
      end
      queue_req(op, page);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    kend_we     = 1'b0;
    kend_data   = '0;
    req.valid   = 1'b0;
    req.op      = OP_INIT;
    req.page    = '0;
    rsp.ready   = 1'b0;
    error_count = 0;
    idle_max    = 3;
    gap_left    = 0;
    stall_left  = 0;
    hold_left   = 0;
    long_hold   = 1'b0;
    req_taken   = 1'b0;
    rsp_taken   = 1'b0;
    model_kend  = '0;
    for (int w = 0; w < WORDS; w++) begin
      model_used[w] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Kernel reservation, alloc, alloc-at, frees, range and reserved ops.
    start_phase(14'd40);
    queue_req(OP_INIT, 20'hFFFFF);
    queue_req(OP_QUERY, 20'd0);
    queue_req(OP_QUERY, 20'd40);
    queue_req(OP_ALLOC, 20'hFFFFF);
    queue_req(OP_ALLOC_AT, 20'd41);
    queue_req(OP_ALLOC_AT, 20'd41);
    queue_req(OP_FREE, 20'd41);
    queue_req(OP_FREE, 20'd41);
    queue_req(OP_FREE, 20'd10);
    queue_req(OP_ALLOC_AT, 20'd8191);
    queue_req(OP_FREE, 20'd8191);
    queue_req(OP_ALLOC_AT, 20'd8192);
    queue_req(OP_FREE, 20'hFFFFF);
    queue_req(OP_QUERY, 20'd8192);
    queue_req(OP_RSVD_LO, 20'hFFFFF);
    queue_req(OP_RSVD_MID, 20'h00000);
    queue_req(OP_RSVD_HI, 20'd5);

    // Lowest free page sits in the least significant bit of a word.
    start_phase(14'd31);
    queue_req(OP_INIT, 20'd0);
    queue_req(OP_ALLOC, 20'd0);
    queue_req(OP_ALLOC, 20'd0);

    // Kernel end covering the whole bitmap: nothing to allocate or free.
    start_phase(14'd8192);
    queue_req(OP_INIT, 20'd0);
    queue_req(OP_ALLOC, 20'd0);
    queue_req(OP_FREE, 20'd100);

    // Free a used page, then refuse a kernel page that is already free.
    start_phase(14'd0);
    queue_req(OP_FREE, 20'd5);
    start_phase(14'd100);
    queue_req(OP_FREE, 20'd5);

    // Random phases over several kernel end settings.
    random_phase(0, 1'b1, 120, 1'b0);
    random_phase($urandom_range(1, 8191), 1'b1, 130, 1'b0);
    random_phase($urandom_range(0, 200), 1'b1, 120, 1'b1);
    idle_max = 0;
    random_phase(8192 - $urandom_range(0, 60), 1'b1, 130, 1'b0);
    idle_max = 3;
    random_phase(8192, 1'b0, 100, 1'b0);
    random_phase($urandom_range(0, 8192), 1'b1, 130, 1'b0);
    random_phase($urandom_range(0, 8192), 1'($urandom_range(0, 1)), 130, 1'b0);
    random_phase(50, 1'b1, 130, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== page_frame_bitmap_allocator_top.f =====
design/pfba_pkg.sv
design/pfba_req_if.sv
design/pfba_rsp_if.sv
design/pfba_ram.sv
design/pfba_seq.sv
design/pfba_dpath.sv
design/page_frame_bitmap_allocator_top.sv
verif/testbench.sv
